// ===== sv/abd_pkg.sv =====
package abd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_W    = 16;
    localparam int STATE_W     = 32;
    localparam int LEVEL_W     = 31;
    localparam int COEFF_W     = 16;
    localparam int THRESH_W    = 15;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int FRAC_SHIFT  = 16;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COEFF_W-1:0]  FILTER_COEFF_RST  = 16'd1400;
    localparam logic [COEFF_W-1:0]  RELEASE_COEFF_RST = 16'd65462;
    localparam logic [THRESH_W-1:0] THRESH_HIGH_RST   = 15'd9830;
    localparam logic [THRESH_W-1:0] THRESH_LOW_RST    = 15'd4915;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_COEFF  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_COEFF = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_HIGH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_LOW    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F1_MUL,
        S_F1_UPD,
        S_F2_MUL,
        S_F2_UPD,
        S_ABS,
        S_ENV_MUL1,
        S_ENV_MUL2,
        S_ENV_UPD,
        S_TRIG
    } t_state;

endpackage

// ===== sv/audio_beat_detector_unit.sv =====
// Beat detector for one audio stream. Each Q1.15 sample runs through two
// one-pole low-pass sections, a peak envelope follower with instant attack
// and exponential release, and a Schmitt trigger; every sample yields one
// beat carrying the beat pulse, the trigger state and the 15-bit envelope.
// A single 33x18 multiplier is shared by the four multiplies of a sample
// under a small sequencer. A new sample is accepted only in the idle step;
// ready stays low while the sequencer runs both filter sections, the
// magnitude step, the release steps if the envelope releases, and the
// trigger step. The result waits in an output register, so the next sample
// is taken while it is still unread; the sequencer holds in its last step,
// adding stall cycles, while an earlier result is still unread. Configuration
// writes are taken in any cycle; write them only while no sample is in flight.
module audio_beat_detector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [abd_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,   // [15:0] sample
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] beat_pulse, [1] beat_active, [16:2] envelope, [23:17] zero
    output logic [abd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [abd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [abd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import abd_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [COEFF_W-1:0]         r_filter_coeff;
    logic [COEFF_W-1:0]         r_release_coeff;
    logic [THRESH_W-1:0]        r_thresh_high;
    logic [THRESH_W-1:0]        r_thresh_low;

    logic signed [STATE_W-1:0]  r_x;
    logic signed [STATE_W-1:0]  r_s1;
    logic signed [STATE_W-1:0]  r_s2;
    logic [LEVEL_W-1:0]         r_peak;
    logic [LEVEL_W-1:0]         r_mag;
    logic                       r_trig_on;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;
    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_out_data;

    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_step;
    logic signed [PROD_W-1:0]   w_blend;
    logic signed [MUL_A_W-1:0]  w_s2_neg;
    logic [LEVEL_W-1:0]         w_mag;
    logic                       w_mag_gt;
    logic                       w_trig_next;
    logic                       w_out_free;
    logic                       w_in_accept;
    logic signed [STATE_W-1:0]  w_x_aligned;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign w_x_aligned = {i_s_axis_tdata[SAMPLE_BITS-1:0], {(STATE_W-SAMPLE_BITS){1'b0}}};

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_step  = r_prod >>> FRAC_SHIFT;
    assign w_blend = r_acc + r_prod;

    assign w_s2_neg = -{r_s2[STATE_W-1], r_s2};
    always_comb begin
        if (!r_s2[STATE_W-1]) begin
            w_mag = r_s2[LEVEL_W-1:0];
        end else if (w_s2_neg[STATE_W]) begin
            w_mag = w_s2_neg[LEVEL_W-1:0];
        end else if (w_s2_neg[STATE_W-1]) begin
            w_mag = {LEVEL_W{1'b1}};
        end else begin
            w_mag = w_s2_neg[LEVEL_W-1:0];
        end
    end
    assign w_mag_gt = w_mag > r_peak;

    always_comb begin
        if (!r_trig_on) begin
            w_trig_next = r_peak > {r_thresh_high, {FRAC_SHIFT{1'b0}}};
        end else begin
            w_trig_next = !(r_peak < {r_thresh_low, {FRAC_SHIFT{1'b0}}});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_in_accept) n_state = S_F1_MUL;
            S_F1_MUL:   n_state = S_F1_UPD;
            S_F1_UPD:   n_state = S_F2_MUL;
            S_F2_MUL:   n_state = S_F2_UPD;
            S_F2_UPD:   n_state = S_ABS;
            S_ABS:      n_state = w_mag_gt ? S_TRIG : S_ENV_MUL1;
            S_ENV_MUL1: n_state = S_ENV_MUL2;
            S_ENV_MUL2: n_state = S_ENV_UPD;
            S_ENV_UPD:  n_state = S_TRIG;
            S_TRIG:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mul_a         = '0;
        w_mul_b         = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_F1_MUL: begin
                w_mul_a = {r_x[STATE_W-1], r_x} - {r_s1[STATE_W-1], r_s1};
                w_mul_b = {2'b00, r_filter_coeff};
            end
            S_F2_MUL: begin
                w_mul_a = {r_s1[STATE_W-1], r_s1} - {r_s2[STATE_W-1], r_s2};
                w_mul_b = {2'b00, r_filter_coeff};
            end
            S_ENV_MUL1: begin
                w_mul_a = {2'b00, r_peak};
                w_mul_b = {2'b00, r_release_coeff};
            end
            S_ENV_MUL2: begin
                w_mul_a = {2'b00, r_mag};
                w_mul_b = 18'sh10000 - {2'b00, r_release_coeff};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_filter_coeff  <= FILTER_COEFF_RST;
            r_release_coeff <= RELEASE_COEFF_RST;
            r_thresh_high   <= THRESH_HIGH_RST;
            r_thresh_low    <= THRESH_LOW_RST;
            r_s1            <= '0;
            r_s2            <= '0;
            r_peak          <= '0;
            r_trig_on       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FILTER_COEFF:  r_filter_coeff  <= i_cfg_data;
                    CFG_RELEASE_COEFF: r_release_coeff <= i_cfg_data;
                    CFG_THRESH_HIGH:   r_thresh_high   <= i_cfg_data[THRESH_W-1:0];
                    CFG_THRESH_LOW:    r_thresh_low    <= i_cfg_data[THRESH_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == S_F1_UPD) begin
                r_s1 <= r_s1 + w_step[STATE_W-1:0];
            end
            if (r_state == S_F2_UPD) begin
                r_s2 <= r_s2 + w_step[STATE_W-1:0];
            end
            if (r_state == S_ABS && w_mag_gt) begin
                r_peak <= w_mag;
            end
            if (r_state == S_ENV_UPD) begin
                r_peak <= w_blend[LEVEL_W+FRAC_SHIFT-1:FRAC_SHIFT];
            end

            if (r_state == S_TRIG && w_out_free) begin
                r_trig_on   <= w_trig_next;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_acc  <= r_prod;
        if (w_in_accept) begin
            r_x <= w_x_aligned;
        end
        if (r_state == S_ABS) begin
            r_mag <= w_mag;
        end
        if (r_state == S_TRIG && w_out_free) begin
            r_out_data <= {{(OUT_DATA_W-THRESH_W-2){1'b0}},
                           r_peak[LEVEL_W-1:FRAC_SHIFT],
                           w_trig_next,
                           w_trig_next && !r_trig_on};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_pulse_implies_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[1])
        else $error("beat pulse without active trigger");

    a_accept_starts_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_state == S_F1_MUL)
        else $error("accepted sample did not start the sequence");

    a_result_from_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_TRIG)
        else $error("result appeared outside the trigger step");

    a_pulse_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TRIG && w_out_free && w_trig_next && !r_trig_on
        |=> o_m_axis_tdata[0] && r_trig_on)
        else $error("trigger rise did not emit a pulse");
`endif

endmodule
